@@ design/adf_pkg.sv @@
// Shared types, constants and fixed-point helpers for the advection-diffusion
// form accumulator. No dependencies; every design file imports this package.
`default_nettype none

package adf_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [30:0] CAP31 = 31'h7FFF_FFFF;
  // 0.45 in fixed point, rounded as the 0.9 * 0.5 shock constant
  localparam logic [30:0] SHOCK_COEF = 31'(((9 << FRAC_BITS) + 10) / 20);
  localparam logic [30:0] DIFF_RESET = 31'(1 << FRAC_BITS);

  localparam logic [2:0] CFG_DIFFUSION  = 3'd0;
  localparam logic [2:0] CFG_VELOCITY_X = 3'd1;
  localparam logic [2:0] CFG_VELOCITY_Y = 3'd2;
  localparam logic [2:0] CFG_SHOCK      = 3'd3;
  localparam logic [2:0] CFG_STAB       = 3'd4;

  // micro-program labels
  localparam logic [4:0] PC_BASE_END  = 5'd7;
  localparam logic [4:0] PC_R_END     = 5'd9;
  localparam logic [4:0] PC_SHOCK_END = 5'd16;
  localparam logic [4:0] PC_STAB      = 5'd17;
  localparam logic [4:0] PC_LAST      = 5'd30;

  localparam logic signed [65:0] SAT_HI = 66'sh7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO = -66'sh8000_0000;
  localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_WAIT,
    ST_FINISH
  } state_e;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_W, SRC_UV, SRC_UDX, SRC_UDY, SRC_VDX, SRC_VDY, SRC_ULAP,
    SRC_VLAP, SRC_H, SRC_EPS, SRC_B1, SRC_B2, SRC_T1, SRC_GD, SRC_RABS,
    SRC_Q, SRC_COEF, SRC_SIX, SRC_BN, SRC_E6, SRC_P, SRC_TAU, SRC_RV, SRC_RU
  } src_e;

  typedef enum logic [3:0] {
    WB_Q, WB_ACC, WB_DOT, WB_ADDADV, WB_QSUB_ADV, WB_QSUB_R, WB_QSUB_T1,
    WB_SUM, WB_P, WB_CAP, WB_SQRT, WB_DIVQ, WB_DIVT
  } wb_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_T1, DST_GD, DST_ADV, DST_R, DST_Q, DST_P, DST_E6, DST_TAU,
    DST_RU, DST_RV, DST_BN, DST_D, DST_DEN
  } dst_e;

  typedef struct packed {
    src_e a;
    src_e b;
    wb_e  wb;
    dst_e dst;
  } uop_t;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sat_add_t;

  function automatic logic signed [31:0] sat32_f(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (x < SAT_LO) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // round to nearest, halves upward, then drop the fraction bits
  function automatic logic signed [65:0] rshift_f(input logic signed [63:0] x);
    logic signed [65:0] t;
    t = $signed({{2{x[63]}}, x}) + ROUND_HALF;
    return t >>> FRAC_BITS;
  endfunction

  function automatic sat_add_t sadd64_f(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
    logic signed [64:0] s;
    sat_add_t r;
    s = $signed({a[63], a}) + $signed({b[63], b});
    r.ovf = s[64] ^ s[63];
    if (r.ovf) r.val = s[64] ? MIN64 : MAX64;
    else r.val = s[63:0];
    return r;
  endfunction

  function automatic uop_t uop_f(input logic [4:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = '{SRC_UDX,  SRC_VDX,  WB_ACC,      DST_NONE};
      5'd1:  u = '{SRC_UDY,  SRC_VDY,  WB_DOT,      DST_GD};
      5'd2:  u = '{SRC_B1,   SRC_UV,   WB_Q,        DST_T1};
      5'd3:  u = '{SRC_T1,   SRC_VDX,  WB_Q,        DST_ADV};
      5'd4:  u = '{SRC_B2,   SRC_UV,   WB_Q,        DST_T1};
      5'd5:  u = '{SRC_T1,   SRC_VDY,  WB_ADDADV,   DST_ADV};
      5'd6:  u = '{SRC_EPS,  SRC_GD,   WB_QSUB_ADV, DST_T1};
      5'd7:  u = '{SRC_W,    SRC_T1,   WB_SUM,      DST_NONE};
      5'd8:  u = '{SRC_B1,   SRC_UDX,  WB_ACC,      DST_NONE};
      5'd9:  u = '{SRC_B2,   SRC_UDY,  WB_DOT,      DST_R};
      5'd10: u = '{SRC_UDX,  SRC_UDX,  WB_ACC,      DST_NONE};
      5'd11: u = '{SRC_UDY,  SRC_UDY,  WB_SQRT,     DST_DEN};
      5'd12: u = '{SRC_ZERO, SRC_ZERO, WB_DIVQ,     DST_Q};
      5'd13: u = '{SRC_COEF, SRC_H,    WB_Q,        DST_T1};
      5'd14: u = '{SRC_T1,   SRC_RABS, WB_Q,        DST_T1};
      5'd15: u = '{SRC_T1,   SRC_Q,    WB_Q,        DST_T1};
      5'd16: u = '{SRC_W,    SRC_T1,   WB_SUM,      DST_NONE};
      5'd17: u = '{SRC_B1,   SRC_B1,   WB_ACC,      DST_NONE};
      5'd18: u = '{SRC_B2,   SRC_B2,   WB_SQRT,     DST_BN};
      5'd19: u = '{SRC_BN,   SRC_H,    WB_P,        DST_P};
      5'd20: u = '{SRC_EPS,  SRC_SIX,  WB_CAP,      DST_E6};
      5'd21: u = '{SRC_E6,   SRC_E6,   WB_ACC,      DST_NONE};
      5'd22: u = '{SRC_P,    SRC_P,    WB_SQRT,     DST_D};
      5'd23: u = '{SRC_H,    SRC_H,    WB_DIVT,     DST_TAU};
      5'd24: u = '{SRC_EPS,  SRC_ULAP, WB_QSUB_R,   DST_RU};
      5'd25: u = '{SRC_B1,   SRC_VDX,  WB_ACC,      DST_NONE};
      5'd26: u = '{SRC_B2,   SRC_VDY,  WB_DOT,      DST_T1};
      5'd27: u = '{SRC_EPS,  SRC_VLAP, WB_QSUB_T1,  DST_RV};
      5'd28: u = '{SRC_TAU,  SRC_RV,   WB_Q,        DST_T1};
      5'd29: u = '{SRC_T1,   SRC_RU,   WB_Q,        DST_T1};
      5'd30: u = '{SRC_W,    SRC_T1,   WB_SUM,      DST_NONE};
      default: u = '{SRC_ZERO, SRC_ZERO, WB_ACC,    DST_NONE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ design/adf_alu.sv @@
// Shared 33 x 33 signed multiplier with a registered product.
// Depends on adf_pkg.
`default_nettype none

module adf_alu
  import adf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [63:0]      prod_o
);

  logic signed [65:0] full;
  logic signed [63:0] prod_q;

  assign full   = a_i * b_i;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[63:0];
    end
  end

endmodule

`default_nettype wire

@@ design/adf_sqrt.sv @@
// Iterative floor square root of a 64-bit unsigned value, two bits per cycle.
// Depends on adf_pkg.
`default_nettype none

module adf_sqrt
  import adf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] x_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh, trial, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, x_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;
  assign done_o  = done_q;
  assign root_o  = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? rem_sub[33:0] : rem_sh[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ design/adf_div.sv @@
// Restoring unsigned divider, 64-bit dividend by 34-bit divisor, one bit a cycle.
// Depends on adf_pkg.
`default_nettype none

module adf_div
  import adf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [33:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [33:0] den_q, rem_q;
  logic [34:0] rem_sh, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, quo_q[63]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? rem_sub[33:0] : rem_sh[33:0];
    end
  end

endmodule

`default_nettype wire

@@ design/advection_diffusion_form_accumulator.sv @@
// Advection-diffusion form accumulator: one quadrature point per transfer.
// Each point runs a micro-program on the shared multiplier, each micro-operation a multiply
// then a writeback; square roots and divides wait in ST_WAIT for their unit. Shock capturing
// and SUPG add optional terms; the SUPG divide is skipped when its denominator is zero.
// The result becomes valid as the block returns to idle; a held result stalls input.
// Reset (async, active low) clears sum, overflow flag, result valid; loads defaults.
`default_nettype none

module advection_diffusion_form_accumulator
  import adf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // point_weight, trial_value, trial_dx, trial_dy, test_dx, test_dy,
  // trial_laplace, test_laplace, elem_diam, zero pad
  input  wire logic [287:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,   // last_point
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // form_value
  output logic              m_axis_tuser    // overflowed
);

  state_e state_q, state_d;
  logic [4:0] pc_q, pc_d, pc_next;
  logic seq_end;
  uop_t uop;

  logic [30:0] w_q, h_q;
  logic signed [31:0] uv_q, udx_q, udy_q, vdx_q, vdy_q, ulap_q, vlap_q;
  logic last_q;

  logic [30:0] eps_q;
  logic signed [31:0] b1_q, b2_q;
  logic shock_q, stab_q;

  logic signed [31:0] t1_q, gd_q, r_q, q_q, ru_q, rv_q;
  logic signed [32:0] adv_q;
  logic [30:0] p_q, e6_q, tau_q;
  logic [31:0] bn_q, d_q;
  logic [32:0] den_q;
  logic signed [63:0] acc_q, sum_q;
  logic ovf_q;

  logic m_valid_q, m_user_q;
  logic [63:0] m_data_q;

  logic signed [32:0] op_a, op_b;
  logic signed [63:0] prod;
  logic in_fire, alu_en;

  logic sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [33:0] div_den;

  logic wr_en, acc_en, sum_en, emit;
  logic signed [33:0] wr_val;

  logic signed [31:0] q_val, dot_val, qsub_val, qd_val, rabs;
  sat_add_t dsum, ssum;
  logic signed [32:0] sub_val;
  logic signed [33:0] qdiff, adv_sum;
  logic [64:0] p_round;
  logic [30:0] p_val, e6_val, tau_val;
  logic [32:0] gd_abs;

  assign uop           = uop_f(pc_q);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign alu_en        = (state_q == ST_MUL);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  function automatic logic signed [32:0] operand(input src_e sel);
    logic signed [32:0] v;
    unique case (sel)
      SRC_ZERO: v = '0;
      SRC_W:    v = $signed({2'b00, w_q});
      SRC_UV:   v = {uv_q[31], uv_q};
      SRC_UDX:  v = {udx_q[31], udx_q};
      SRC_UDY:  v = {udy_q[31], udy_q};
      SRC_VDX:  v = {vdx_q[31], vdx_q};
      SRC_VDY:  v = {vdy_q[31], vdy_q};
      SRC_ULAP: v = {ulap_q[31], ulap_q};
      SRC_VLAP: v = {vlap_q[31], vlap_q};
      SRC_H:    v = $signed({2'b00, h_q});
      SRC_EPS:  v = $signed({2'b00, eps_q});
      SRC_B1:   v = {b1_q[31], b1_q};
      SRC_B2:   v = {b2_q[31], b2_q};
      SRC_T1:   v = {t1_q[31], t1_q};
      SRC_GD:   v = {gd_q[31], gd_q};
      SRC_RABS: v = {rabs[31], rabs};
      SRC_Q:    v = {q_q[31], q_q};
      SRC_COEF: v = $signed({2'b00, SHOCK_COEF});
      SRC_SIX:  v = 33'sd6;
      SRC_BN:   v = $signed({1'b0, bn_q});
      SRC_E6:   v = $signed({2'b00, e6_q});
      SRC_P:    v = $signed({2'b00, p_q});
      SRC_TAU:  v = $signed({2'b00, tau_q});
      SRC_RV:   v = {rv_q[31], rv_q};
      SRC_RU:   v = {ru_q[31], ru_q};
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = operand(uop.a);
    op_b = operand(uop.b);
  end

  adf_alu u_alu (
    .clk_i  (clk_i),
    .en_i   (alu_en),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  adf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (64'(acc_q + prod)),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  adf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // writeback arithmetic
  always_comb begin
    rabs    = (r_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF : (r_q[31] ? -r_q : r_q);
    q_val   = sat32_f(rshift_f(prod));
    dsum    = sadd64_f(acc_q, prod);
    dot_val = sat32_f(rshift_f(dsum.val));
    ssum    = sadd64_f(sum_q, prod);
    unique case (uop.wb)
      WB_QSUB_ADV: sub_val = adv_q;
      WB_QSUB_R:   sub_val = {r_q[31], r_q};
      default:     sub_val = {t1_q[31], t1_q};
    endcase
    qdiff    = $signed({{2{q_val[31]}}, q_val}) - $signed({sub_val[32], sub_val});
    qsub_val = sat32_f($signed({{32{qdiff[33]}}, qdiff}));
    adv_sum  = $signed({adv_q[32], adv_q}) + $signed({{2{q_val[31]}}, q_val});
    p_round  = ({1'b0, prod} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    p_val    = (p_round > {34'd0, CAP31}) ? CAP31 : p_round[30:0];
    e6_val   = ($unsigned(prod) > {33'd0, CAP31}) ? CAP31 : prod[30:0];
    tau_val  = (div_quo > {33'd0, CAP31}) ? CAP31 : div_quo[30:0];
    qd_val   = sat32_f(gd_q[31] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo}));
    gd_abs   = gd_q[31] ? 33'(-{gd_q[31], gd_q}) : {1'b0, gd_q};
    if (uop.wb == WB_DIVQ) begin
      div_num = 64'(gd_abs) << FRAC_BITS;
      div_den = {1'b0, den_q};
    end else begin
      div_num = prod;
      div_den = {1'b0, d_q, 1'b0};
    end
  end

  // next program counter
  always_comb begin
    seq_end = 1'b0;
    pc_next = pc_q + 5'd1;
    priority if (pc_q == PC_BASE_END) begin
      seq_end = !(shock_q || stab_q);
    end else if (pc_q == PC_R_END) begin
      if (!shock_q) pc_next = PC_STAB;
    end else if (pc_q == PC_SHOCK_END) begin
      seq_end = !stab_q;
    end else if (pc_q == PC_LAST) begin
      seq_end = 1'b1;
    end else begin
      seq_end = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    wr_en      = 1'b0;
    wr_val     = '0;
    acc_en     = 1'b0;
    sum_en     = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_MUL;
          pc_d    = '0;
        end
      end
      ST_MUL: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        state_d = seq_end ? ST_FINISH : ST_MUL;
        pc_d    = pc_next;
        unique case (uop.wb)
          WB_Q: begin
            wr_en  = 1'b1;
            wr_val = 34'(q_val);
          end
          WB_ACC: acc_en = 1'b1;
          WB_DOT: begin
            wr_en  = 1'b1;
            wr_val = 34'(dot_val);
          end
          WB_ADDADV: begin
            wr_en  = 1'b1;
            wr_val = adv_sum;
          end
          WB_QSUB_ADV, WB_QSUB_R, WB_QSUB_T1: begin
            wr_en  = 1'b1;
            wr_val = 34'(qsub_val);
          end
          WB_SUM: sum_en = 1'b1;
          WB_P: begin
            wr_en  = 1'b1;
            wr_val = $signed({3'b000, p_val});
          end
          WB_CAP: begin
            wr_en  = 1'b1;
            wr_val = $signed({3'b000, e6_val});
          end
          WB_SQRT: begin
            sqrt_start = 1'b1;
            state_d    = ST_WAIT;
            pc_d       = pc_q;
          end
          WB_DIVQ: begin
            div_start = 1'b1;
            state_d   = ST_WAIT;
            pc_d      = pc_q;
          end
          WB_DIVT: begin
            if (d_q == '0) begin
              wr_en  = 1'b1;
              wr_val = $signed({3'b000, CAP31});
            end else begin
              div_start = 1'b1;
              state_d   = ST_WAIT;
              pc_d      = pc_q;
            end
          end
          default: ;
        endcase
      end
      ST_WAIT: begin
        if ((uop.wb == WB_SQRT && sqrt_done) || (uop.wb != WB_SQRT && div_done)) begin
          state_d = seq_end ? ST_FINISH : ST_MUL;
          pc_d    = pc_next;
          wr_en   = 1'b1;
          priority if (uop.wb == WB_SQRT) begin
            wr_val = (uop.dst == DST_DEN) ? $signed({2'b00, sqrt_root}) + 34'sd1
                                          : $signed({2'b00, sqrt_root});
          end else if (uop.wb == WB_DIVQ) begin
            wr_val = 34'(qd_val);
          end else begin
            wr_val = $signed({3'b000, tau_val});
          end
        end
      end
      ST_FINISH: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!m_valid_q || m_axis_tready) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= DIFF_RESET;
      b1_q    <= '0;
      b2_q    <= '0;
      shock_q <= 1'b0;
      stab_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIFFUSION:  eps_q   <= cfg_wdata_i[30:0];
        CFG_VELOCITY_X: b1_q    <= cfg_wdata_i;
        CFG_VELOCITY_Y: b2_q    <= cfg_wdata_i;
        CFG_SHOCK:      shock_q <= cfg_wdata_i[0];
        CFG_STAB:       stab_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // hold the point for the whole sequence
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      w_q    <= s_axis_tdata[30:0];
      uv_q   <= s_axis_tdata[62:31];
      udx_q  <= s_axis_tdata[94:63];
      udy_q  <= s_axis_tdata[126:95];
      vdx_q  <= s_axis_tdata[158:127];
      vdy_q  <= s_axis_tdata[190:159];
      ulap_q <= s_axis_tdata[222:191];
      vlap_q <= s_axis_tdata[254:223];
      h_q    <= s_axis_tdata[285:255];
      last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      acc_q <= prod;
    end
    if (wr_en) begin
      unique case (uop.dst)
        DST_T1:  t1_q  <= wr_val[31:0];
        DST_GD:  gd_q  <= wr_val[31:0];
        DST_ADV: adv_q <= wr_val[32:0];
        DST_R:   r_q   <= wr_val[31:0];
        DST_Q:   q_q   <= wr_val[31:0];
        DST_P:   p_q   <= wr_val[30:0];
        DST_E6:  e6_q  <= wr_val[30:0];
        DST_TAU: tau_q <= wr_val[30:0];
        DST_RU:  ru_q  <= wr_val[31:0];
        DST_RV:  rv_q  <= wr_val[31:0];
        DST_BN:  bn_q  <= wr_val[31:0];
        DST_D:   d_q   <= wr_val[31:0];
        DST_DEN: den_q <= wr_val[32:0];
        default: ;
      endcase
    end
  end

  // running sum: saturate and keep the overflow sticky until the next result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (emit) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (sum_en) begin
      sum_q <= ssum.val;
      if (ssum.ovf) ovf_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= sum_q;
      m_user_q <= ovf_q;
    end
  end

endmodule

`default_nettype wire

@@ bench/advection_diffusion_form_accumulator_test.sv @@
// Self-checking bench for advection_diffusion_form_accumulator: queued quadrature points
// driven over the input stream, element sums predicted in fixed point and checked.
// Depends on adf_pkg and the accumulator RTL only.
`timescale 1ns / 100ps

module advection_diffusion_form_accumulator_test;
  import adf_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    bit [30:0] w;
    bit [31:0] uv, udx, udy, vdx, vdy, ulap, vlap;
    bit [30:0] h;
    bit        last;
  } point_t;

  typedef struct {
    longint value;
    bit     ovf;
  } form_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  advection_diffusion_form_accumulator i_dut (.*);

  always #1 clk_i = ~clk_i;

  point_t pending_points[$];
  form_t  expected_forms[$];
  point_t cur_point;
  bit     in_took = 1'b0;
  int     src_idle_pct = 0;
  int     dst_stall_pct = 0;
  int     errors = 0;
  int     quiet_cycles = 0;

  // predictor copy of the registers and the element state
  longint cfg_eps = 65536, cfg_b1 = 0, cfg_b2 = 0;
  bit     cfg_shock = 1'b0, cfg_stab = 1'b0;
  longint elem_sum = 0;
  bit     elem_ovf = 1'b0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint round_shift(longint x);
    return (x >>> FRAC_BITS) + ((x >>> (FRAC_BITS - 1)) & 64'sd1);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32(round_shift(a * b));
  endfunction

  function automatic longint sat_add(longint a, longint b, inout bit ovf);
    longint max_v, min_v;
    max_v = 64'sh7FFF_FFFF_FFFF_FFFF;
    min_v = 64'sh8000_0000_0000_0000;
    if (b > 0 && a > max_v - b) begin
      ovf = 1'b1;
      return max_v;
    end
    if (b < 0 && a < min_v - b) begin
      ovf = 1'b1;
      return min_v;
    end
    return a + b;
  endfunction

  function automatic longint qdot(longint a1, longint c1, longint a2, longint c2);
    bit ignore;
    ignore = 1'b0;
    return sat32(round_shift(sat_add(a1 * c1, a2 * c2, ignore)));
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic add_term(longint w, longint inner);
    elem_sum = sat_add(elem_sum, w * inner, elem_ovf);
  endtask

  // add one point's integrand; queue the element sum on its last point
  task automatic integrate_point(point_t p);
    longint w, uv, udx, udy, vdx, vdy, ulap, vlap, h, gd, adv, r, den, q, kr;
    longint ru, rv;
    bit [63:0] g2, bn, e6, pr, d, tau;
    form_t f;
    w = longint'(p.w);
    h = longint'(p.h);
    uv = longint'($signed(p.uv));
    udx = longint'($signed(p.udx));
    udy = longint'($signed(p.udy));
    vdx = longint'($signed(p.vdx));
    vdy = longint'($signed(p.vdy));
    ulap = longint'($signed(p.ulap));
    vlap = longint'($signed(p.vlap));
    gd = qdot(udx, vdx, udy, vdy);
    adv = qmul(qmul(cfg_b1, uv), vdx) + qmul(qmul(cfg_b2, uv), vdy);
    add_term(w, sat32(qmul(cfg_eps, gd) - adv));
    if (cfg_shock) begin
      r = qdot(cfg_b1, udx, cfg_b2, udy);
      g2 = 64'(udx * udx) + 64'(udy * udy);
      den = longint'(floor_sqrt(g2)) + 1;
      q = sat32((gd * 64'sd65536) / den);
      if (r < 0) r = sat32(-r);
      kr = qmul(qmul(longint'(SHOCK_COEF), h), r);
      add_term(w, qmul(kr, q));
    end
    if (cfg_stab) begin
      bn = floor_sqrt(64'(cfg_b1 * cfg_b1) + 64'(cfg_b2 * cfg_b2));
      e6 = 64'(6 * cfg_eps);
      pr = (bn * 64'(h) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (e6 > 64'(CAP31)) e6 = 64'(CAP31);
      if (pr > 64'(CAP31)) pr = 64'(CAP31);
      d = floor_sqrt(e6 * e6 + pr * pr);
      if (d == 0) begin
        tau = 64'(CAP31);
      end else begin
        tau = (64'(h) * 64'(h)) / (2 * d);
        if (tau > 64'(CAP31)) tau = 64'(CAP31);
      end
      ru = sat32(qmul(cfg_eps, ulap) - qdot(cfg_b1, udx, cfg_b2, udy));
      rv = sat32(qmul(cfg_eps, vlap) - qdot(cfg_b1, vdx, cfg_b2, vdy));
      add_term(w, qmul(qmul(longint'(tau), rv), ru));
    end
    if (p.last) begin
      f.value = elem_sum;
      f.ovf = elem_ovf;
      expected_forms.push_back(f);
      elem_sum = 0;
      elem_ovf = 1'b0;
    end
  endtask

  // input side: predict on every transfer
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      integrate_point(cur_point);
      in_took <= 1'b1;
    end else begin
      in_took <= 1'b0;
    end
  end

  // driver: advance at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_took)) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_point = pending_points.pop_front();
        s_axis_tdata <= {2'b0, cur_point.h, cur_point.vlap, cur_point.ulap, cur_point.vdy,
                         cur_point.vdx, cur_point.udy, cur_point.udx, cur_point.uv,
                         cur_point.w};
        s_axis_tlast <= cur_point.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= dst_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_forms.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h/%b", $realtime,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        form_t f;
        f = expected_forms.pop_front();
        if (m_axis_tdata !== 64'(f.value)) begin
          errors++;
          $display("%0t: form_value expected %h actual %h", $realtime, 64'(f.value),
                   m_axis_tdata);
        end
        if (m_axis_tuser !== f.ovf) begin
          errors++;
          $display("%0t: overflowed expected %b actual %b", $realtime, f.ovf, m_axis_tuser);
        end
      end
    end
  end

  // watchdog: count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DIFFUSION:  cfg_eps = longint'(val[30:0]);
      CFG_VELOCITY_X: cfg_b1 = longint'($signed(val));
      CFG_VELOCITY_Y: cfg_b2 = longint'($signed(val));
      CFG_SHOCK:      cfg_shock = val[0];
      CFG_STAB:       cfg_stab = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [31:0] eps, logic [31:0] b1, logic [31:0] b2, bit shock,
                           bit stab);
    write_reg(CFG_DIFFUSION, eps);
    write_reg(CFG_VELOCITY_X, b1);
    write_reg(CFG_VELOCITY_Y, b2);
    write_reg(CFG_SHOCK, 32'(shock));
    write_reg(CFG_STAB, 32'(stab));
  endtask

  function automatic bit [31:0] rand_val();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return $urandom();
    if (sel < 80) return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    if (sel < 90) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return '0;
  endfunction

  function automatic bit [30:0] rand_pos();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return 31'($urandom());
    if (sel < 90) return 31'($urandom_range(1 << 18));
    return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd1;
  endfunction

  function automatic point_t rand_point(bit last);
    point_t p;
    p.w = rand_pos();
    p.uv = rand_val();
    p.udx = rand_val();
    p.udy = rand_val();
    p.vdx = rand_val();
    p.vdy = rand_val();
    p.ulap = rand_val();
    p.vlap = rand_val();
    p.h = rand_pos();
    p.last = last;
    return p;
  endfunction

  // elements of one to eight points
  task automatic queue_elements(int points);
    int n;
    while (points > 0) begin
      n = $urandom_range(8, 1);
      for (int k = 0; k < n; k++) pending_points.push_back(rand_point(k == n - 1));
      points -= n;
    end
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || s_axis_tvalid || expected_forms.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic point_t fixed_point(bit [31:0] v, bit [30:0] w, bit [30:0] h, bit last);
    point_t p;
    p = '{w, v, v, v, v, v, v, v, h, last};
    return p;
  endfunction

  initial begin
    point_t p;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults after reset, then writes to unused indexes that must be ignored
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    pending_points.push_back(fixed_point(32'h0001_0000, 31'h0001_0000, 31'h1_0000, 1'b1));
    drain();

    // directed: both optional terms on
    configure(32'h0000_8000, 32'h0002_0000, 32'hFFFF_0000, 1'b1, 1'b1);
    pending_points.push_back(fixed_point(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1));
    pending_points.push_back(fixed_point(32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1));
    pending_points.push_back(fixed_point(32'h0, 31'h0, 31'h0, 1'b1));
    pending_points.push_back(fixed_point(32'h0003_0000, 31'h0001_0000, 31'h0, 1'b1));
    pending_points.push_back(fixed_point(32'hFFFD_0000, 31'h0001_0000, 31'd1, 1'b0));
    pending_points.push_back(fixed_point(32'h0000_0001, 31'd1, 31'h0002_0000, 1'b1));
    // repeated large positive terms saturate the sum
    for (int k = 0; k < 4; k++) begin
      p = fixed_point(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, k == 3);
      p.uv = '0;
      pending_points.push_back(p);
    end
    for (int k = 0; k < 4; k++) begin
      p = fixed_point(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0, k == 3);
      p.vdx = 32'h8000_0000;
      p.vdy = 32'h8000_0000;
      p.uv = '0;
      pending_points.push_back(p);
    end
    drain();

    // extreme registers, then zero diffusion and velocity (SUPG denominator zero)
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    pending_points.push_back(fixed_point(32'h0001_0000, 31'h0001_0000, 31'h0004_0000, 1'b1));
    pending_points.push_back(fixed_point(32'h7FFF_FFFF, 31'h0000_0100, 31'h7FFF_FFFF, 1'b1));
    drain();
    configure(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    pending_points.push_back(fixed_point(32'h0002_0000, 31'h0001_0000, 31'h0003_0000, 1'b1));
    pending_points.push_back(fixed_point(32'hFFFF_8000, 31'h0001_0000, 31'h0, 1'b1));
    drain();

    // random phases across settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 63; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 63; end
        default: begin src_idle_pct = 37; dst_stall_pct = 37; end
      endcase
      configure({1'b0, rand_pos()}, rand_val(), rand_val(), ph[0], ph[1]);
      queue_elements(ph < 4 ? 260 : 170);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
